### hw/rtl/alist_pkg.sv
// alist_pkg: shared types and codes for the array list unit
// word formats, request and status codes, controller states, control/status bundles
// no dependencies
package alist_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_ILLEGAL   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         position;
        logic signed [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] found_position;
        logic [7:0] length;
    } rsp_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_UP,
        S_UP_DRAIN,
        S_WRITE_NEW,
        S_DOWN,
        S_DOWN_DRAIN,
        S_SCAN,
        S_SCAN_TAIL,
        S_RESP
    } state_t;

    typedef struct packed {
        logic       latch_req;
        logic       load_up;
        logic       load_down;
        logic       load_scan;
        logic       rd_en;
        logic       ptr_down;
        logic       shift_wr;
        logic       write_new;
        logic       count_inc;
        logic       count_dec;
        logic       set_status;
        logic [1:0] status_code;
        logic       set_found;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       ins_illegal;
        logic       ins_append;
        logic       del_illegal;
        logic       del_tail;
        logic       list_empty;
        logic       up_last;
        logic       ptr_at_end;
        logic       hit;
        logic       out_free;
    } dp_stat_t;

endpackage

### hw/rtl/array_list_insert_delete_find_unit.sv
// Ordered list of up to CAPACITY signed 32-bit values in a single-port-write, registered-read
// entry memory. One request is worked at a time and each gives one response word. An insert
// shifts the entries from position to the tail up one slot before writing the new value, and
// a delete shifts the entries above position down one slot; an error, an append or a delete
// at the last entry skips the shift. A find scans from entry 0 until a hit or the last entry,
// and answers not found without a scan on an empty list. The memory moves or compares one entry
// per cycle, and the unit returns to idle before the next request is taken. A new request is
// taken once the previous one is in the output register, even while that response still
// waits to be taken. Reset empties the list; the memory itself needs no clearing.
module array_list_insert_delete_find_unit #(
    parameter int CAPACITY = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  alist_pkg::req_word_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output alist_pkg::rsp_word_t rsp
);
    import alist_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    alist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    alist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### hw/rtl/alist_dp.sv
// alist_dp: datapath of the array list unit
// entry memory, count, read pointer, one-deep read lag for shifts and scans, result register
// depends on alist_pkg
module alist_dp #(
    parameter int CAPACITY = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alist_pkg::req_word_t  req,
    output alist_pkg::rsp_word_t  rsp,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  alist_pkg::ctrl_cmd_t  cmd,
    output alist_pkg::dp_stat_t   stat
);
    import alist_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]    entry_mem [CAPACITY];
    logic [31:0]    rd_data_reg;

    req_word_t      req_reg;
    logic [CW-1:0]  count_reg,    count_next;
    logic [IW-1:0]  ptr_reg,      ptr_next;
    logic           lag_valid_reg;
    logic [IW-1:0]  lag_addr_reg;
    logic [1:0]     res_status_reg, res_status_next;
    logic [IW-1:0]  res_found_reg,  res_found_next;
    logic           out_valid_reg,  out_valid_next;
    rsp_word_t      out_word_reg;

    logic [IW-1:0]  pos_idx;
    logic [IW-1:0]  last_idx;
    logic [8:0]     pos9;
    logic [8:0]     cnt9;
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [31:0]    wr_data;

    assign pos_idx  = req_reg.position[IW-1:0];
    assign last_idx = IW'(count_reg - 1'b1);
    assign pos9     = {1'b0, req_reg.position};
    assign cnt9     = 9'(count_reg);

    always_comb
    begin
        stat.kind        = req_reg.req_type;
        stat.full        = (count_reg == CW'(CAPACITY));
        stat.ins_illegal = (pos9 > cnt9);
        stat.ins_append  = (pos9 == cnt9);
        stat.del_illegal = (pos9 >= cnt9);
        stat.del_tail    = ((pos9 + 9'd1) == cnt9);
        stat.list_empty  = (count_reg == '0);
        stat.up_last     = (ptr_reg == pos_idx);
        stat.ptr_at_end  = (ptr_reg == last_idx);
        stat.hit         = lag_valid_reg && (rd_data_reg == $unsigned(req_reg.value));
        stat.out_free    = !out_valid_reg || rsp_ready;
    end

    // shift writes land one slot above (insert) or below (delete) the entry read last cycle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_idx;
        wr_data = $unsigned(req_reg.value);
        if (cmd.write_new)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_wr && lag_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
            if (req_reg.req_type == REQ_INSERT)
                wr_addr = lag_addr_reg + 1'b1;
            else
                wr_addr = lag_addr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= entry_mem[ptr_reg];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
            count_next = count_reg + 1'b1;
        else if (cmd.count_dec)
            count_next = count_reg - 1'b1;

        ptr_next = ptr_reg;
        if (cmd.load_up)
            ptr_next = last_idx;
        else if (cmd.load_down)
            ptr_next = pos_idx + 1'b1;
        else if (cmd.load_scan)
            ptr_next = '0;
        else if (cmd.rd_en)
            ptr_next = cmd.ptr_down ? ptr_reg - 1'b1 : ptr_reg + 1'b1;

        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        if (cmd.latch_req)
        begin
            res_status_next = ST_OK;
            res_found_next  = '0;
        end
        else
        begin
            if (cmd.set_status)
                res_status_next = cmd.status_code;
            if (cmd.set_found)
                res_found_next = lag_addr_reg;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            lag_valid_reg <= cmd.rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
            req_reg <= req;
        ptr_reg        <= ptr_next;
        lag_addr_reg   <= ptr_reg;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        if (cmd.out_load)
        begin
            out_word_reg.status         <= res_status_reg;
            out_word_reg.found_position <= 7'(res_found_reg);
            out_word_reg.length         <= 8'(count_reg);
        end
    end

    assign rsp       = out_word_reg;
    assign rsp_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg)) ||
            (count_reg == CW'($past(count_reg) + 1'b1)) ||
            (count_reg == CW'($past(count_reg) - 1'b1)))
        else $error("entry count moved by more than one");

    a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.found_position == 7'd0)
        else $error("nonzero found position on a failed request");
`endif

endmodule

### hw/rtl/alist_ctrl.sv
// alist_ctrl: sequencer of the array list unit
// steps each request through check, shift or scan and response; commands the datapath
// depends on alist_pkg
module alist_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  alist_pkg::dp_stat_t  stat,
    output alist_pkg::ctrl_cmd_t cmd
);
    import alist_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_CHECK;
                end
            end

            S_CHECK:
            begin
                state_next = S_RESP;
                unique case (stat.kind)
                    REQ_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                        end
                        else if (stat.ins_illegal)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ILLEGAL;
                        end
                        else if (stat.ins_append)
                        begin
                            state_next = S_WRITE_NEW;
                        end
                        else
                        begin
                            cmd.load_up = 1'b1;
                            state_next  = S_UP;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (stat.del_illegal)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ILLEGAL;
                        end
                        else if (stat.del_tail)
                        begin
                            cmd.count_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.load_down = 1'b1;
                            state_next    = S_DOWN;
                        end
                    end
                    REQ_FIND:
                    begin
                        if (stat.list_empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.load_scan = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // unused request type answers ok with the current length
                    end
                endcase
            end

            S_UP:
            begin
                cmd.rd_en    = 1'b1;
                cmd.ptr_down = 1'b1;
                cmd.shift_wr = 1'b1;
                if (stat.up_last)
                    state_next = S_UP_DRAIN;
            end

            S_UP_DRAIN:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_WRITE_NEW;
            end

            S_WRITE_NEW:
            begin
                cmd.write_new = 1'b1;
                cmd.count_inc = 1'b1;
                state_next    = S_RESP;
            end

            S_DOWN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.shift_wr = 1'b1;
                if (stat.ptr_at_end)
                    state_next = S_DOWN_DRAIN;
            end

            S_DOWN_DRAIN:
            begin
                cmd.shift_wr  = 1'b1;
                cmd.count_dec = 1'b1;
                state_next    = S_RESP;
            end

            S_SCAN:
            begin
                // compare runs one entry behind the read
                cmd.rd_en = 1'b1;
                if (stat.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_RESP;
                end
                else if (stat.ptr_at_end)
                begin
                    state_next = S_SCAN_TAIL;
                end
            end

            S_SCAN_TAIL:
            begin
                if (stat.hit)
                begin
                    cmd.set_found = 1'b1;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_CHECK)
        else $error("accepted request did not enter check");
`endif

endmodule
